@@ rtl/deq_pkg.sv @@
package deq_pkg;

	// Ring size and derived widths
	localparam int DEPTH   = 1024;
	localparam int AW      = $clog2(DEPTH);
	localparam int COUNT_W = 11;

	typedef logic [AW-1:0]      idx_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic signed [31:0] word_t;
	typedef logic [2:0]         func_t;
	typedef logic [1:0]         status_t;

	localparam count_t DEPTH_COUNT = COUNT_W'(DEPTH);
	localparam word_t  NO_WORD     = '1;

	// Operation codes
	localparam func_t FN_NONE       = 3'd0;
	localparam func_t FN_PUSH_FRONT = 3'd1;
	localparam func_t FN_PUSH_BACK  = 3'd2;
	localparam func_t FN_POP_FRONT  = 3'd3;
	localparam func_t FN_POP_BACK   = 3'd4;

	// Status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_POP_EMPTY = 2'd1;
	localparam status_t ST_PUSH_FULL = 2'd2;

	// Store access for one cycle: one write, two prefetch reads
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		word_t wdata;
		idx_t  raddr_a;
		idx_t  raddr_b;
	} mem_req_t;

	// Ring index step forward, wrapping
	function automatic idx_t idx_inc(input idx_t i);
		idx_t r;
		if (i == idx_t'(DEPTH - 1)) r = '0;
		else r = i + idx_t'(1);
		return r;
	endfunction

	// Ring index step backward, wrapping
	function automatic idx_t idx_dec(input idx_t i);
		idx_t r;
		if (i == '0) r = idx_t'(DEPTH - 1);
		else r = i - idx_t'(1);
		return r;
	endfunction

endpackage

@@ rtl/deq_store.sv @@
module deq_store
	import deq_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output word_t    rdata_a_q,
	output word_t    rdata_b_q
);

	word_t mem [DEPTH];

	// One write port, two registered read ports; a read of the slot being
	// written this cycle returns the new word
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.we && req.raddr_a == req.waddr) begin
			rdata_a_q <= req.wdata;
		end else begin
			rdata_a_q <= mem[req.raddr_a];
		end
		if (req.we && req.raddr_b == req.waddr) begin
			rdata_b_q <= req.wdata;
		end else begin
			rdata_b_q <= mem[req.raddr_b];
		end
	end

endmodule

@@ rtl/deq_core.sv @@
module deq_core
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	// item held in the input stage
	input  logic     item_valid,
	input  func_t    item_func,
	input  word_t    item_value,
	output logic     item_take,
	// store access
	output mem_req_t mem_req,
	input  word_t    second_front,
	input  word_t    second_back,
	// result register
	output logic     res_valid,
	input  logic     res_ready,
	output word_t    res_popped,
	output status_t  res_status,
	output count_t   res_count,
	output logic     res_empty,
	output word_t    res_front,
	output word_t    res_back
);

	// Queue pointers and cached end words
	idx_t   head_q, tail_q;
	count_t count_q;
	word_t  front_q, back_q;

	// Result register
	logic    res_valid_q;
	word_t   popped_q, front_out_q, back_out_q;
	status_t status_q;
	count_t  count_out_q;
	logic    empty_q;

	idx_t    n_head, n_tail;
	count_t  n_count;
	word_t   n_front, n_back, popped;
	status_t status;
	logic    we, full, empty;
	idx_t    waddr;

	assign item_take = item_valid && (!res_valid_q || res_ready);
	assign full      = (count_q == DEPTH_COUNT);
	assign empty     = (count_q == '0);

	// Next state for the item in the input stage
	always_comb begin
		n_head  = head_q;
		n_tail  = tail_q;
		n_count = count_q;
		n_front = front_q;
		n_back  = back_q;
		popped  = '0;
		status  = ST_OK;
		we      = 1'b0;
		waddr   = idx_dec(head_q);
		if (item_take) begin
			case (item_func)
				FN_PUSH_FRONT: begin
					if (full) begin
						status = ST_PUSH_FULL;
					end else begin
						n_head  = idx_dec(head_q);
						waddr   = n_head;
						we      = 1'b1;
						n_count = count_q + count_t'(1);
						n_front = item_value;
						if (empty) n_back = item_value;
					end
				end
				FN_PUSH_BACK: begin
					if (full) begin
						status = ST_PUSH_FULL;
					end else begin
						n_tail  = idx_inc(tail_q);
						waddr   = n_tail;
						we      = 1'b1;
						n_count = count_q + count_t'(1);
						n_back  = item_value;
						if (empty) n_front = item_value;
					end
				end
				FN_POP_FRONT: begin
					if (empty) begin
						popped = NO_WORD;
						status = ST_POP_EMPTY;
					end else begin
						popped  = front_q;
						n_head  = idx_inc(head_q);
						n_count = count_q - count_t'(1);
						n_front = second_front;
					end
				end
				FN_POP_BACK: begin
					if (empty) begin
						popped = NO_WORD;
						status = ST_POP_EMPTY;
					end else begin
						popped  = back_q;
						n_tail  = idx_dec(tail_q);
						n_count = count_q - count_t'(1);
						n_back  = second_back;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Prefetch the words next to both ends of the next state
	always_comb begin
		mem_req.we      = we;
		mem_req.waddr   = waddr;
		mem_req.wdata   = item_value;
		mem_req.raddr_a = idx_inc(n_head);
		mem_req.raddr_b = idx_dec(n_tail);
	end

	// Pointer and count state; tail trails head by one when empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= idx_t'(DEPTH - 1);
			count_q <= '0;
		end else begin
			head_q  <= n_head;
			tail_q  <= n_tail;
			count_q <= n_count;
		end
	end

	always_ff @(posedge clk) begin
		front_q <= n_front;
		back_q  <= n_back;
	end

	// Result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item_take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (item_take) begin
			popped_q    <= popped;
			status_q    <= status;
			count_out_q <= n_count;
			empty_q     <= (n_count == '0);
			front_out_q <= (n_count == '0) ? NO_WORD : n_front;
			back_out_q  <= (n_count == '0) ? NO_WORD : n_back;
		end
	end

	assign res_valid  = res_valid_q;
	assign res_popped = popped_q;
	assign res_status = status_q;
	assign res_count  = count_out_q;
	assign res_empty  = empty_q;
	assign res_front  = front_out_q;
	assign res_back   = back_out_q;

endmodule

@@ rtl/double_ended_queue.sv @@
// Channel  Handshake             Payload
// input    in_valid / in_ready   func, push_value
// output   out_valid / out_ready popped_value, status, entry_count, is_empty,
//                                front_value, back_value
//
// One item per cycle sustained while out_ready stays high. An accepted item waits in the input register,
// then its result is loaded into the result register.
// End words are cached in registers and their neighbors prefetched from the store each cycle.
// Reset sets the pointers and clears the count and the valid flags; the store is not cleared.
// A stalled output holds its result, the input stage keeps one item, in_ready drops.
module double_ended_queue
	import deq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  func_t   func,
	input  word_t   push_value,
	output logic    out_valid,
	input  logic    out_ready,
	output word_t   popped_value,
	output status_t status,
	output count_t  entry_count,
	output logic    is_empty,
	output word_t   front_value,
	output word_t   back_value
);

	logic     valid_s1;
	func_t    func_s1;
	word_t    push_value_s1;
	logic     take;
	mem_req_t mem_req;
	word_t    second_front, second_back;

	assign in_ready = !valid_s1 || take;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1       <= func;
			push_value_s1 <= push_value;
		end
	end

	deq_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.item_func    (func_s1),
		.item_value   (push_value_s1),
		.item_take    (take),
		.mem_req      (mem_req),
		.second_front (second_front),
		.second_back  (second_back),
		.res_valid    (out_valid),
		.res_ready    (out_ready),
		.res_popped   (popped_value),
		.res_status   (status),
		.res_count    (entry_count),
		.res_empty    (is_empty),
		.res_front    (front_value),
		.res_back     (back_value)
	);

	deq_store u_store (
		.clk       (clk),
		.req       (mem_req),
		.rdata_a_q (second_front),
		.rdata_b_q (second_back)
	);

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= DEPTH_COUNT)
		else $error("entry count above depth");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (front_value == NO_WORD && back_value == NO_WORD))
		else $error("empty queue shows end words");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_POP_EMPTY) |-> (popped_value == NO_WORD && is_empty))
		else $error("pop on empty result inconsistent");

	a_take_one: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !(in_valid && in_ready)) |=> !valid_s1)
		else $error("input stage not drained after take");
`endif

endmodule
